/* rtl/dcfl_pkg.sv */
// Package for the dual-channel FIR low-pass: constants, coefficient ROM, controller types.
`timescale 1ns / 1ps

package dcfl_pkg;

    // Default configuration of the filter.
    localparam int DEF_TAP_COUNT   = 51;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COEFF_BITS  = 18;

    // Coefficient ROM geometry; every stored value fits in ROM_BITS unsigned bits.
    localparam int ROM_LEN   = 51;
    localparam int ROM_BITS  = 13;
    localparam int ROM_IDX_W = $clog2(ROM_LEN);
    localparam int TAP_IDX_W = 8;

    localparam logic [ROM_BITS-1:0] COEFF_ROM [0:ROM_LEN-1] = '{
        13'd0,    13'd22,   13'd50,   13'd93,   13'd155,  13'd244,  13'd364,
        13'd522,  13'd720,  13'd962,  13'd1247, 13'd1573, 13'd1939, 13'd2338,
        13'd2763, 13'd3206, 13'd3656, 13'd4102, 13'd4532, 13'd4935, 13'd5299,
        13'd5613, 13'd5868, 13'd6056, 13'd6171, 13'd6210, 13'd6171, 13'd6056,
        13'd5868, 13'd5613, 13'd5299, 13'd4935, 13'd4532, 13'd4102, 13'd3656,
        13'd3206, 13'd2763, 13'd2338, 13'd1939, 13'd1573, 13'd1247, 13'd962,
        13'd720,  13'd522,  13'd364,  13'd244,  13'd155,  13'd93,   13'd50,
        13'd22,   13'd0
    };

    // Coefficient of a tap; taps past the end of the ROM weigh zero.
    function automatic logic [ROM_BITS-1:0] coeff_at(input logic [TAP_IDX_W-1:0] idx);
        logic [ROM_BITS-1:0] value;
        value = '0;
        if (idx < TAP_IDX_W'(ROM_LEN)) begin
            value = COEFF_ROM[idx[ROM_IDX_W-1:0]];
        end
        return value;
    endfunction

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

/* rtl/dcfl_channels.sv */
// Valid/ready channel interfaces for the sample pair input and the filtered pair output.
`timescale 1ns / 1ps

interface dcfl_in_if #(
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] red_ac;
    logic signed [SAMPLE_BITS-1:0] infrared_ac;

    modport source (output valid, output red_ac, output infrared_ac, input ready);
    modport sink   (input valid, input red_ac, input infrared_ac, output ready);
endinterface

interface dcfl_out_if #(
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] red_filtered;
    logic signed [SAMPLE_BITS-1:0] infrared_filtered;

    modport source (output valid, output red_filtered, output infrared_filtered, input ready);
    modport sink   (input valid, input red_filtered, input infrared_filtered, output ready);
endinterface

/* rtl/dual_channel_fir_lowpass.sv */
// A sample pair is filtered by a sweep of one tap per cycle over a history read address shared by
// both channels, with one multiply-accumulate lane per channel; a new pair is accepted only after
// the previous result has been loaded into the output register.
// A pending output does not block the next input; the result loads once the output is free.
// Reset: synchronous active-low i_rst_n clears control state, the write pointer and the
// history valid bits, so both histories read as zero at once with no clearing pass.
`timescale 1ns / 1ps

module dual_channel_fir_lowpass #(
    parameter int TAP_COUNT   = dcfl_pkg::DEF_TAP_COUNT,
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_BITS  = dcfl_pkg::DEF_COEFF_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcfl_in_if.sink    i_in,
    dcfl_out_if.source o_out
);
    import dcfl_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Sequencer.
    dcfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Filter datapath.
    dcfl_datapath #(
        .TAP_COUNT   (TAP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_red_ac            (i_in.red_ac),
        .i_infrared_ac       (i_in.infrared_ac),
        .o_out_valid         (o_out.valid),
        .i_out_ready         (o_out.ready),
        .o_red_filtered      (o_out.red_filtered),
        .o_infrared_filtered (o_out.infrared_filtered)
    );

endmodule

/* rtl/dcfl_ctrl.sv */
// Controller state machine that sequences the tap sweep of the two multiply-accumulate lanes.
`timescale 1ns / 1ps

module dcfl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dcfl_pkg::t_status i_status,
    output dcfl_pkg::t_cmd    o_cmd
);
    import dcfl_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dcfl_datapath.sv */
// Datapath: sample histories, coefficient lookup, two multiply-accumulate lanes, rounding, output.
`timescale 1ns / 1ps

module dcfl_datapath #(
    parameter int TAP_COUNT   = dcfl_pkg::DEF_TAP_COUNT,
    parameter int SAMPLE_BITS = dcfl_pkg::DEF_SAMPLE_BITS,
    parameter int COEFF_BITS  = dcfl_pkg::DEF_COEFF_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcfl_pkg::t_cmd                i_cmd,
    output dcfl_pkg::t_status             o_status,
    input  logic signed [SAMPLE_BITS-1:0] i_red_ac,
    input  logic signed [SAMPLE_BITS-1:0] i_infrared_ac,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_red_filtered,
    output logic signed [SAMPLE_BITS-1:0] o_infrared_filtered
);
    import dcfl_pkg::*;

    localparam int AW      = $clog2(TAP_COUNT);
    localparam int FRAC    = COEFF_BITS - 1;
    localparam int PROD_W  = SAMPLE_BITS + ROM_BITS + 1;
    localparam int SUM_W   = PROD_W + AW;
    localparam int ACC_W   = (SUM_W > FRAC + 2) ? SUM_W : FRAC + 2;
    localparam logic [AW-1:0] LAST_IDX = AW'(TAP_COUNT - 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // History memories and their per-entry valid bits (unwritten entries read as zero).
    logic [SAMPLE_BITS-1:0] r_mem_red [0:TAP_COUNT-1];
    logic [SAMPLE_BITS-1:0] r_mem_ir  [0:TAP_COUNT-1];
    logic [TAP_COUNT-1:0]   r_written;

    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_tap;

    logic                          r_s1_go;
    logic                          r_s1_ok;
    logic [SAMPLE_BITS-1:0]        r_s1_red;
    logic [SAMPLE_BITS-1:0]        r_s1_ir;
    logic [ROM_BITS-1:0]           r_s1_coef;

    logic                          r_s2_go;
    logic signed [PROD_W-1:0]      r_s2_prod_red;
    logic signed [PROD_W-1:0]      r_s2_prod_ir;

    logic signed [ACC_W-1:0]       r_acc_red;
    logic signed [ACC_W-1:0]       r_acc_ir;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_red;
    logic signed [SAMPLE_BITS-1:0] r_out_ir;

    logic signed [SAMPLE_BITS-1:0] s1_red_masked;
    logic signed [SAMPLE_BITS-1:0] s1_ir_masked;
    logic signed [ROM_BITS:0]      s1_coef_signed;
    logic signed [ACC_W-1:0]       rnd_red;
    logic signed [ACC_W-1:0]       rnd_ir;
    logic signed [SAMPLE_BITS-1:0] sat_red;
    logic signed [SAMPLE_BITS-1:0] sat_ir;

    // Sample write on accept; registered read during the sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem_red[r_wr_ptr] <= i_red_ac;
            r_mem_ir[r_wr_ptr]  <= i_infrared_ac;
        end
        r_s1_red <= r_mem_red[r_rd_addr];
        r_s1_ir  <= r_mem_ir[r_rd_addr];
    end

    // Valid bits, write pointer, sweep address and tap counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_wr_ptr  <= '0;
            r_rd_addr <= '0;
            r_tap     <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_written[r_wr_ptr] <= 1'b1;
                r_rd_addr           <= r_wr_ptr;
                r_tap               <= '0;
            end else if (i_cmd.issue) begin
                r_rd_addr <= (r_rd_addr == '0) ? LAST_IDX : r_rd_addr - 1'b1;
                r_tap     <= r_tap + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
            end
        end
    end

    // Stage one: read data, its valid bit and the tap coefficient.
    always_ff @(posedge i_clk) begin
        r_s1_ok   <= r_written[r_rd_addr];
        r_s1_coef <= coeff_at(TAP_IDX_W'(r_tap));
    end

    assign s1_red_masked  = r_s1_ok ? signed'(r_s1_red) : '0;
    assign s1_ir_masked   = r_s1_ok ? signed'(r_s1_ir) : '0;
    assign s1_coef_signed = signed'({1'b0, r_s1_coef});

    // Stage two: one product per channel.
    always_ff @(posedge i_clk) begin
        r_s2_prod_red <= PROD_W'(s1_red_masked * s1_coef_signed);
        r_s2_prod_ir  <= PROD_W'(s1_ir_masked * s1_coef_signed);
    end

    // Pipeline occupancy flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go <= 1'b0;
            r_s2_go <= 1'b0;
        end else begin
            r_s1_go <= i_cmd.issue;
            r_s2_go <= r_s1_go;
        end
    end

    // Accumulators, cleared when a new transaction is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc_red <= '0;
            r_acc_ir  <= '0;
        end else if (r_s2_go) begin
            r_acc_red <= r_acc_red + {{(ACC_W-PROD_W){r_s2_prod_red[PROD_W-1]}}, r_s2_prod_red};
            r_acc_ir  <= r_acc_ir + {{(ACC_W-PROD_W){r_s2_prod_ir[PROD_W-1]}}, r_s2_prod_ir};
        end
    end

    // Round to nearest with ties upward, return to sample scale and saturate.
    always_comb begin
        rnd_red = (r_acc_red + ROUND_HALF) >>> FRAC;
        rnd_ir  = (r_acc_ir + ROUND_HALF) >>> FRAC;
        if (rnd_red > SAT_HI) begin
            sat_red = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd_red < SAT_LO) begin
            sat_red = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_red = rnd_red[SAMPLE_BITS-1:0];
        end
        if (rnd_ir > SAT_HI) begin
            sat_ir = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd_ir < SAT_LO) begin
            sat_ir = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_ir = rnd_ir[SAMPLE_BITS-1:0];
        end
    end

    // Output register holding the result until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_red <= sat_red;
            r_out_ir  <= sat_ir;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_red_filtered      = r_out_red;
    assign o_infrared_filtered = r_out_ir;

    // Status back to the controller.
    assign o_status.last_tap  = (r_tap == LAST_IDX);
    assign o_status.pipe_busy = r_s1_go | r_s2_go;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule
